### sv/bmms_pkg.sv
`default_nettype none

package bmms_pkg;

    // Bin geometry and storage widths.
    localparam int NUM_BINS   = 12;
    localparam int COUNT_BITS = 16;
    localparam int MONTHS     = 12;
    localparam int NBIN       = (NUM_BINS < MONTHS) ? NUM_BINS : MONTHS;
    localparam int IDX_W      = (NBIN > 1) ? $clog2(NBIN) : 1;

    // Field widths of the input and result items.
    localparam int YEAR_W     = 14;
    localparam int MONTH_W    = 4;
    localparam int TEMP_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 16;
    localparam int MEAN_W     = 12;
    localparam int FRAC_W     = 4;

    // Accumulator and divider widths.
    localparam int SUM_W      = COUNT_BITS + TEMP_W;
    localparam int STEP_W     = $clog2(MEAN_W);

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_OTHER_YEAR = 2'd1,
        ST_BAD_MONTH  = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### sv/bmms_ctrl.sv
`default_nettype none

module bmms_ctrl
    import bmms_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = (r_state == S_IDLE) && i_s_axis_tvalid;
        o_cmd.update   = (r_state == S_UPDATE);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.load_out = (r_state == S_FINISH) && i_status.out_free;
    end

    a_accept_starts_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_UPDATE))
        else $error("accepted item did not start a bin update");

    a_load_needs_free_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("result loaded over a pending result");

    a_div_runs_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> o_cmd.div_step)
        else $error("divider did not start after the bin update");

endmodule

`default_nettype wire

### sv/bmms_datapath.sv
`default_nettype none

module bmms_datapath
    import bmms_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                  i_m_axis_tready,
    output t_dp_status                 o_status,
    output logic                       o_m_axis_tvalid,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    // Captured input item.
    logic [YEAR_W-1:0]  r_in_year;
    logic [MONTH_W-1:0] r_in_month;
    logic [TEMP_W-1:0]  r_in_temp;

    // Bin storage; only the counts need clearing, the rest is rewritten
    // by the first sample of an empty bin.
    logic [YEAR_W-1:0]     r_bin_year  [NBIN];
    logic [TEMP_W-1:0]     r_bin_min   [NBIN];
    logic [TEMP_W-1:0]     r_bin_max   [NBIN];
    logic [SUM_W-1:0]      r_bin_sum   [NBIN];
    logic [COUNT_BITS-1:0] r_bin_count [NBIN];

    // Result under construction and the mean divider.
    t_status               r_res_status;
    logic [COUNT_BITS-1:0] r_res_cnt;
    logic [TEMP_W-1:0]     r_res_min;
    logic [TEMP_W-1:0]     r_res_max;
    logic                  r_neg;
    logic [COUNT_BITS-1:0] r_rem;
    logic [MEAN_W-1:0]     r_shift;
    logic [COUNT_BITS-1:0] r_div;
    logic [MEAN_W-1:0]     r_quo;
    logic [STEP_W-1:0]     r_step;

    // Output register.
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [CNT_OUT_W-1:0]  r_out_cnt;
    logic [TEMP_W-1:0]     r_out_min;
    logic [TEMP_W-1:0]     r_out_max;
    logic [MEAN_W-1:0]     r_out_mean;

    logic [MONTH_W-1:0]    w_month_m1;
    logic                  w_month_ok;
    logic [IDX_W-1:0]      w_idx;
    logic [COUNT_BITS-1:0] w_cur_cnt;
    logic [YEAR_W-1:0]     w_cur_year;
    logic [TEMP_W-1:0]     w_cur_min;
    logic [TEMP_W-1:0]     w_cur_max;
    logic [SUM_W-1:0]      w_cur_sum;
    logic [SUM_W-1:0]      w_temp_ext;
    t_status               w_stat;
    logic                  w_write;
    logic [COUNT_BITS-1:0] w_new_cnt;
    logic [TEMP_W-1:0]     w_new_min;
    logic [TEMP_W-1:0]     w_new_max;
    logic [SUM_W-1:0]      w_new_sum;
    logic [SUM_W-1:0]      w_mag;
    logic [SUM_W+FRAC_W-1:0] w_dvd;
    logic [COUNT_BITS:0]   w_trial;
    logic                  w_ge;
    logic [COUNT_BITS:0]   w_diff;
    logic [MEAN_W-1:0]     w_mean;
    logic [31:0]           w_cnt_wide;

    assign w_month_m1 = r_in_month - MONTH_W'(1);
    assign w_month_ok = (r_in_month != '0) && (r_in_month <= MONTH_W'(MONTHS))
                        && (32'(w_month_m1) < NBIN);
    assign w_idx      = w_month_m1[IDX_W-1:0];

    always_comb begin
        w_cur_cnt  = '0;
        w_cur_year = '0;
        w_cur_min  = '0;
        w_cur_max  = '0;
        w_cur_sum  = '0;
        if (w_month_ok) begin
            w_cur_cnt  = r_bin_count[w_idx];
            w_cur_year = r_bin_year[w_idx];
            w_cur_min  = r_bin_min[w_idx];
            w_cur_max  = r_bin_max[w_idx];
            w_cur_sum  = r_bin_sum[w_idx];
        end
    end

    assign w_temp_ext = {{(SUM_W-TEMP_W){r_in_temp[TEMP_W-1]}}, r_in_temp};

    // Status and updated bin contents; a dropped sample leaves the bin as it is.
    always_comb begin
        w_stat    = ST_OK;
        w_write   = 1'b0;
        w_new_cnt = w_cur_cnt;
        w_new_min = w_cur_min;
        w_new_max = w_cur_max;
        w_new_sum = w_cur_sum;
        priority if (!w_month_ok) begin
            w_stat = ST_BAD_MONTH;
        end else if (w_cur_cnt == '0) begin
            w_write   = 1'b1;
            w_new_cnt = COUNT_BITS'(1);
            w_new_min = r_in_temp;
            w_new_max = r_in_temp;
            w_new_sum = w_temp_ext;
        end else if (w_cur_year != r_in_year) begin
            w_stat = ST_OTHER_YEAR;
        end else if (w_cur_cnt == COUNT_MAX) begin
            w_stat = ST_FULL;
        end else begin
            w_write   = 1'b1;
            w_new_cnt = w_cur_cnt + COUNT_BITS'(1);
            w_new_sum = w_cur_sum + w_temp_ext;
            if ($signed(r_in_temp) < $signed(w_cur_min)) begin
                w_new_min = r_in_temp;
            end
            if ($signed(r_in_temp) > $signed(w_cur_max)) begin
                w_new_max = r_in_temp;
            end
        end
    end

    // The mean never exceeds 2048 in magnitude, so the top COUNT_BITS bits of
    // the scaled dividend are already below the count and seed the remainder.
    assign w_mag = w_new_sum[SUM_W-1] ? (SUM_W'(0) - w_new_sum) : w_new_sum;
    assign w_dvd = {w_mag, FRAC_W'(0)};

    assign w_trial = {r_rem, r_shift[MEAN_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in_year  <= i_s_axis_tdata[YEAR_W-1:0];
            r_in_month <= i_s_axis_tdata[YEAR_W+MONTH_W-1:YEAR_W];
            r_in_temp  <= i_s_axis_tdata[YEAR_W+MONTH_W+TEMP_W-1:YEAR_W+MONTH_W];
        end
        if (i_cmd.update) begin
            r_res_status <= w_stat;
            r_res_cnt    <= w_new_cnt;
            r_res_min    <= w_new_min;
            r_res_max    <= w_new_max;
            r_neg        <= w_new_sum[SUM_W-1];
            r_rem        <= w_dvd[SUM_W+FRAC_W-1:MEAN_W];
            r_shift      <= w_dvd[MEAN_W-1:0];
            r_div        <= w_new_cnt;
            r_quo        <= '0;
            r_step       <= '0;
        end else if (i_cmd.div_step) begin
            r_rem   <= w_ge ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
            r_shift <= {r_shift[MEAN_W-2:0], 1'b0};
            r_quo   <= {r_quo[MEAN_W-2:0], w_ge};
            r_step  <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NBIN; i++) begin
                r_bin_count[i] <= '0;
            end
        end else if (i_cmd.update && w_write) begin
            r_bin_count[w_idx] <= w_new_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && w_write) begin
            r_bin_year[w_idx] <= r_in_year;
            r_bin_min[w_idx]  <= w_new_min;
            r_bin_max[w_idx]  <= w_new_max;
            r_bin_sum[w_idx]  <= w_new_sum;
        end
    end

    assign w_mean     = (r_res_status == ST_BAD_MONTH) ? '0
                      : (r_neg ? (MEAN_W'(0) - r_quo) : r_quo);
    assign w_cnt_wide = 32'(r_res_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_cnt    <= w_cnt_wide[CNT_OUT_W-1:0];
            r_out_min    <= r_res_min;
            r_out_max    <= r_res_max;
            r_out_mean   <= w_mean;
        end
    end

    assign o_status.div_last = (r_step == STEP_W'(MEAN_W - 1));
    assign o_status.out_free = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - STATUS_W - CNT_OUT_W - 2*TEMP_W - MEAN_W)'(0),
                              r_out_mean, r_out_max, r_out_min, r_out_cnt, r_out_status};

    a_bad_month_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_BAD_MONTH)) |->
        ((r_out_cnt == '0) && (r_out_min == '0) && (r_out_max == '0) && (r_out_mean == '0)))
        else $error("bad-month result carries bin statistics");

    a_ok_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_OK)) |-> (r_out_cnt != '0) || (COUNT_BITS > 16))
        else $error("accepted sample reported an empty bin");

    a_mean_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_BAD_MONTH)) |->
        (($signed({{4{r_out_mean[MEAN_W-1]}}, r_out_mean}) >=
          $signed({r_out_min, 4'b0000}))
         && ($signed({{4{r_out_mean[MEAN_W-1]}}, r_out_mean}) <=
          $signed({r_out_max, 4'b0000}))))
        else $error("mean lies outside the bin's minimum and maximum");

endmodule

`default_nettype wire

### sv/binned_min_max_mean_stats_unit.sv
// Binned minimum / maximum / mean statistics, one bin per calendar month.
//
// Input stream (s_axis): one item per sample, tdata = year, month, temperature.
// Output stream (m_axis): exactly one result item per input item, in order,
// carrying a status and the month bin's count, minimum, maximum and mean.
//
// Each item is accepted, then the bin is read and updated, a restoring
// divider produces the twelve-bit mean one bit per cycle, and the result is
// loaded into the output register, from where it appears on m_axis. A new
// item is taken only once the previous one has reached the output register,
// so the block does not take a new item while one is still in flight.
//
// The result sits in an output register; while the receiver holds tready low
// the result stays put and the block still takes and processes the next item,
// stalling only when that next result is ready and the register is occupied.
//
// Reset empties every bin at once (all counts cleared); the block is ready
// for an item as soon as reset is released.
`default_nettype none

module binned_min_max_mean_stats_unit
    import bmms_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // sample_year[13:0], sample_month[17:14], sample_temp[25:18], zero fill
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // status[1:0], bin_count_out[17:2], bin_min_out[25:18], bin_max_out[33:26],
    // bin_mean_out[45:34], zero fill
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    bmms_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    bmms_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_m_axis_tready (i_m_axis_tready),
        .o_status        (w_status),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

### bench/tb.sv
module tb;
    import bmms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [YEAR_W-1:0]         year;
        logic [MONTH_W-1:0]        month;
        logic signed [TEMP_W-1:0]  temp;
        bit                        burst;
    } t_sample;

    typedef struct {
        t_status                   status;
        logic [CNT_OUT_W-1:0]      count;
        logic signed [TEMP_W-1:0]  lo;
        logic signed [TEMP_W-1:0]  hi;
        logic signed [MEAN_W-1:0]  mean;
    } t_report;

    localparam int RANDOM_ITEMS = 500;
    localparam int LONG_HOLD    = 400;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_DATA_W-1:0]   s_data = '0;
    logic                   m_ready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;

    // Samples waiting to be offered, and reports predicted but not yet seen.
    t_sample pending_samples[$];
    t_report stats_expected[$];

    // Shadow of the month bins.
    logic [YEAR_W-1:0]         bin_year[NBIN];
    logic signed [TEMP_W-1:0]  bin_lo[NBIN];
    logic signed [TEMP_W-1:0]  bin_hi[NBIN];
    int                        bin_total[NBIN];
    int                        bin_n[NBIN];

    // What the generator has already sent to each month, so that most random
    // samples carry the year that the bin has taken.
    logic [YEAR_W-1:0]  sent_year[1:MONTHS];
    bit                 sent_any[1:MONTHS];

    bit  sample_taken = 1'b0;
    bit  quiet = 1'b0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  reports_seen = 0;
    int  errors = 0;

    binned_min_max_mean_stats_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < NBIN; i++) begin
            bin_year[i] = '0;
            bin_lo[i] = '0;
            bin_hi[i] = '0;
            bin_total[i] = 0;
            bin_n[i] = 0;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(30, 120);
    endfunction

    // Applies one sample to the shadow bins and returns the report it causes.
    function automatic t_report predict_sample(t_sample s);
        t_report r;
        int      m;
        int      idx;
        int      t;
        longint  scaled;
        r = '{ST_BAD_MONTH, '0, '0, '0, '0};
        m = s.month;
        t = $signed(s.temp);
        if (m < 1 || m > MONTHS || m - 1 >= NBIN) begin
            return r;
        end
        idx = m - 1;
        r.status = ST_OK;
        if (bin_n[idx] == 0) begin
            bin_year[idx] = s.year;
            bin_lo[idx] = s.temp;
            bin_hi[idx] = s.temp;
            bin_total[idx] = 0;
        end else if (bin_year[idx] != s.year) begin
            r.status = ST_OTHER_YEAR;
        end else if (bin_n[idx] >= int'(COUNT_MAX)) begin
            r.status = ST_FULL;
        end
        if (r.status == ST_OK) begin
            if (t > bin_hi[idx]) begin
                bin_hi[idx] = s.temp;
            end
            if (t < bin_lo[idx]) begin
                bin_lo[idx] = s.temp;
            end
            bin_total[idx] += t;
            bin_n[idx] += 1;
        end
        scaled = 0;
        if (bin_n[idx] != 0) begin
            // Signed division in SystemVerilog truncates toward zero.
            scaled = (longint'(bin_total[idx]) * (1 << FRAC_W)) / longint'(bin_n[idx]);
        end
        r.count = bin_n[idx][CNT_OUT_W-1:0];
        r.lo = bin_lo[idx];
        r.hi = bin_hi[idx];
        r.mean = scaled[MEAN_W-1:0];
        return r;
    endfunction

    task automatic queue_sample(input int year, input int month, input int temp,
                                input bit burst);
        t_sample s;
        s.year = year[YEAR_W-1:0];
        s.month = month[MONTH_W-1:0];
        s.temp = temp[TEMP_W-1:0];
        s.burst = burst;
        pending_samples.push_back(s);
        if (month >= 1 && month <= MONTHS && !sent_any[month]) begin
            sent_any[month] = 1'b1;
            sent_year[month] = s.year;
        end
    endtask

    task automatic note_mismatch(input string field, input longint want, input longint got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    // Sender: a new item goes up at a falling edge once the last one was taken and any idle gap has run out.
    always @(negedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || sample_taken) begin
            sample_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s = pending_samples.pop_front();
                quiet = s.burst;
                s_valid <= 1'b1;
                s_data <= {{(IN_DATA_W - YEAR_W - MONTH_W - TEMP_W){1'b0}},
                           s.temp, s.month, s.year};
                send_gap = s.burst ? 0 : idle_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off early in the run so that
    // the output register fills and the input side has to stall.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && reports_seen >= 10) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                stall_left = idle_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_sample s;
        t_report want;
        t_report got;
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready) begin
                s.year = s_data[YEAR_W-1:0];
                s.month = s_data[YEAR_W +: MONTH_W];
                s.temp = s_data[YEAR_W + MONTH_W +: TEMP_W];
                s.burst = 1'b0;
                stats_expected.push_back(predict_sample(s));
                sample_taken = 1'b1;
            end
            if (o_m_axis_tvalid && m_ready) begin
                reports_seen++;
                got.status = t_status'(o_m_axis_tdata[STATUS_W-1:0]);
                got.count = o_m_axis_tdata[STATUS_W +: CNT_OUT_W];
                got.lo = o_m_axis_tdata[STATUS_W + CNT_OUT_W +: TEMP_W];
                got.hi = o_m_axis_tdata[STATUS_W + CNT_OUT_W + TEMP_W +: TEMP_W];
                got.mean = o_m_axis_tdata[STATUS_W + CNT_OUT_W + 2*TEMP_W +: MEAN_W];
                if (stats_expected.size() == 0) begin
                    $display("%0t ns: unexpected result item, expected none, actual data %h",
                             $time, o_m_axis_tdata);
                    errors++;
                end else begin
                    want = stats_expected.pop_front();
                    if (got.status != want.status) begin
                        note_mismatch("status", want.status, got.status);
                    end
                    if (got.count != want.count) begin
                        note_mismatch("count", want.count, got.count);
                    end
                    if (got.lo != want.lo) begin
                        note_mismatch("minimum", want.lo, got.lo);
                    end
                    if (got.hi != want.hi) begin
                        note_mismatch("maximum", want.hi, got.hi);
                    end
                    if (got.mean != want.mean) begin
                        note_mismatch("mean", want.mean, got.mean);
                    end
                end
            end
        end
    end

    initial begin
        int r;
        int m;
        int year;
        for (int i = 1; i <= MONTHS; i++) begin
            sent_any[i] = 1'b0;
            sent_year[i] = '0;
        end

        // Months outside 1 to 12 are dropped with all statistics zero.
        queue_sample(2024, 0, 5, 1'b0);
        queue_sample(2024, 13, -1, 1'b0);
        queue_sample(2024, 14, -128, 1'b0);
        queue_sample(2024, 15, 127, 1'b0);
        // An empty bin takes the first year it sees, then refuses any other.
        queue_sample(0, 1, -128, 1'b0);
        queue_sample(0, 1, 127, 1'b0);
        queue_sample(0, 1, 0, 1'b0);
        queue_sample(9999, 1, 3, 1'b0);
        queue_sample(9999, 12, 127, 1'b0);
        queue_sample(9999, 12, 127, 1'b0);
        queue_sample(9999, 12, -128, 1'b0);
        queue_sample(1, 12, 0, 1'b0);
        // Means that need truncation toward zero on both sides.
        queue_sample(10922, 3, -1, 1'b0);
        queue_sample(10922, 3, 0, 1'b0);
        queue_sample(10922, 3, 0, 1'b0);
        queue_sample(1234, 4, 1, 1'b0);
        queue_sample(1234, 4, 0, 1'b0);
        queue_sample(1234, 4, 0, 1'b0);
        // The extreme means, sent back to back.
        queue_sample(5461, 5, 127, 1'b1);
        queue_sample(5461, 5, 127, 1'b1);
        queue_sample(8191, 6, -128, 1'b1);
        queue_sample(8191, 6, -128, 1'b0);

        // Mostly samples that match the bin's year, with some other years and
        // some bad months mixed in.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                m = $urandom_range(0, 4);
                m = (m == 0) ? 0 : MONTHS + m;
                year = $urandom_range(0, 9999);
            end else begin
                m = $urandom_range(1, MONTHS);
                if (r < 20 || !sent_any[m]) begin
                    year = $urandom_range(0, 9999);
                end else begin
                    year = sent_year[m];
                end
            end
            queue_sample(year, m, $urandom_range(0, 255), 1'b0);
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_samples.size() != 0 || s_valid) begin
            @(posedge i_clk);
        end
        while (stats_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);

        if (errors == 0 && stats_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
